// ===== sv/dmx_pkg.sv =====
// ----------------------------------------------------------------------------
// dmx_pkg
// shared types and constants of the dmx512 frame transmitter
// ----------------------------------------------------------------------------
package dmx_pkg;

  // item kinds taken from the input stream flag
  typedef enum logic {
    ITEM_TICK = 1'b0,
    ITEM_BYTE = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  data;
  } item_t;

  typedef enum logic [1:0] {
    PH_BREAK = 2'd0,
    PH_MAB   = 2'd1,
    PH_DATA  = 2'd2,
    PH_WAIT  = 2'd3
  } line_phase_t;

  typedef enum logic [1:0] {
    PARSE_LOW  = 2'd0,
    PARSE_HIGH = 2'd1,
    PARSE_DATA = 2'd2
  } parse_phase_t;

  typedef logic [1:0] bank_t;

  localparam bank_t BANK_ZERO = 2'd0;
  localparam bank_t BANK_ONE  = 2'd1;
  localparam bank_t BANK_TWO  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_TICKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAB_TICKS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MBB_TICKS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOTS        = 3'd5;
  localparam int unsigned CFG_DATA_W = 20;

  typedef struct packed {
    logic [15:0] break_ticks;
    logic [15:0] mab_ticks;
    logic [15:0] mbb_ticks;
    logic [19:0] min_period_ticks;
    logic [7:0]  bit_ticks;
    logic [9:0]  min_slots;
  } cfg_t;

  localparam logic [15:0] RST_BREAK_TICKS      = 16'd100;
  localparam logic [15:0] RST_MAB_TICKS        = 16'd12;
  localparam logic [15:0] RST_MBB_TICKS        = 16'd50;
  localparam logic [19:0] RST_MIN_PERIOD_TICKS = 20'd5000;
  localparam logic [7:0]  RST_BIT_TICKS        = 8'd4;
  localparam logic [9:0]  RST_MIN_SLOTS        = 10'd24;

  // slots sent after reset before any host frame
  localparam int unsigned RST_SLOT_COUNT = 24;

  localparam int unsigned TICK_W = 20;
  localparam logic [TICK_W-1:0] TICK_MAX = 20'hFFFFF;

  // start bit, eight data bits, two stop bits
  localparam int unsigned BITS_PER_SLOT = 11;
  localparam logic [3:0] LAST_BIT = 4'd10;
  localparam logic [3:0] LAST_DATA_BIT = 4'd8;

  typedef struct packed {
    bank_t       fill_bank;
    bank_t       ready_bank;
    bank_t       transmit_bank;
    line_phase_t line_phase;
  } status_t;

endpackage

// ===== sv/dmx_front.sv =====
// ----------------------------------------------------------------------------
// dmx_front
// input queue: takes stream items, tags ticks and host bytes
// ----------------------------------------------------------------------------
module dmx_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tuser,
  output logic            q_valid,
  output dmx_pkg::item_t  q_item,
  input  logic            q_pop
);

  dmx_pkg::item_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  dmx_pkg::item_t item_in;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_comb begin
    item_in.kind = s_tuser ? dmx_pkg::ITEM_BYTE : dmx_pkg::ITEM_TICK;
    item_in.data = s_tdata;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== sv/dmx_store.sv =====
// ----------------------------------------------------------------------------
// dmx_store
// three banks of slot bytes with a fill count per bank
// ----------------------------------------------------------------------------
module dmx_store #(
  parameter int MAX_SLOTS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  dmx_pkg::bank_t               wr_bank,
  input  logic [$clog2(MAX_SLOTS)-1:0] wr_pos,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en,
  input  logic                         rd_clr,
  input  dmx_pkg::bank_t               rd_bank,
  input  logic [$clog2(MAX_SLOTS)-1:0] rd_pos,
  output logic [7:0]                   rd_byte
);

  localparam int POS_W  = $clog2(MAX_SLOTS);
  localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
  localparam int DEPTH  = 3 * MAX_SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [SLOT_W-1:0] fill_count [3];
  logic [7:0]        rd_q;
  logic              rd_zero;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = ADDR_W'(ADDR_W'(wr_bank) * ADDR_W'(MAX_SLOTS)) + ADDR_W'(wr_pos);
  assign rd_addr = ADDR_W'(ADDR_W'(rd_bank) * ADDR_W'(MAX_SLOTS)) + ADDR_W'(rd_pos);

  // entries at or beyond a bank's fill count were never written and read as zero
  assign rd_byte = rd_zero ? 8'd0 : rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count[0] <= '0;
      fill_count[1] <= '0;
      fill_count[2] <= '0;
      rd_zero       <= 1'b1;
    end else begin
      if (wr_en && (SLOT_W'(wr_pos) >= fill_count[wr_bank])) begin
        fill_count[wr_bank] <= SLOT_W'(wr_pos) + SLOT_W'(1);
      end
      if (rd_clr) begin
        rd_zero <= 1'b1;
      end else if (rd_en) begin
        rd_zero <= (SLOT_W'(rd_pos) >= fill_count[rd_bank]);
      end
    end
  end

endmodule

// ===== sv/dmx_engine.sv =====
// ----------------------------------------------------------------------------
// dmx_engine
// host frame parser, bank rotation and serial line sequencer
// ----------------------------------------------------------------------------
module dmx_engine #(
  parameter int MAX_SLOTS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dmx_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  input  dmx_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,
  output logic                         wr_en,
  output dmx_pkg::bank_t               wr_bank,
  output logic [$clog2(MAX_SLOTS)-1:0] wr_pos,
  output logic [7:0]                   wr_data,
  output logic                         rd_en,
  output logic                         rd_clr,
  output dmx_pkg::bank_t               rd_bank,
  output logic [$clog2(MAX_SLOTS)-1:0] rd_pos,
  input  logic [7:0]                   rd_byte,
  output dmx_pkg::status_t             status
);

  localparam int POS_W    = $clog2(MAX_SLOTS);
  localparam int SLOT_W   = $clog2(MAX_SLOTS + 1);
  localparam int BYTE_W   = $clog2(MAX_SLOTS + 2);
  localparam int FRAME_W  = SLOT_W + 5;
  localparam int WIRE_W   = SLOT_W + 15;
  localparam int TICK_W   = dmx_pkg::TICK_W;

  dmx_pkg::parse_phase_t parse_phase, parse_phase_next;
  logic [7:0]            count_low_byte, count_low_byte_next;
  logic [SLOT_W-1:0]     expected_slots, expected_slots_next;
  logic [SLOT_W-1:0]     received_slots, received_slots_next;
  dmx_pkg::bank_t        fill_bank, fill_bank_next;
  dmx_pkg::bank_t        ready_bank, ready_bank_next;
  dmx_pkg::bank_t        transmit_bank, transmit_bank_next;
  logic [SLOT_W-1:0]     ready_slot_count, ready_slot_count_next;
  logic [SLOT_W-1:0]     transmit_slot_count, transmit_slot_count_next;
  logic                  new_frame_pending, new_frame_pending_next;
  dmx_pkg::line_phase_t  line_phase, line_phase_next;
  logic [15:0]           phase_ticks, phase_ticks_next;
  logic [TICK_W-1:0]     frame_ticks, frame_ticks_next;
  logic [BYTE_W-1:0]     byte_position, byte_position_next;
  logic [3:0]            bit_position, bit_position_next;
  logic                  line_register, line_register_next;

  logic                  advance;
  logic                  begin_flag;
  logic                  commit_flag;
  logic                  error_flag;
  dmx_pkg::line_phase_t  tick_phase;
  logic [15:0]           tick_count;
  logic [16:0]           count_inc;
  logic [TICK_W-1:0]     frame_base;
  logic [BYTE_W-1:0]     byte_inc;
  logic [SLOT_W-1:0]     received_inc;
  logic [15:0]           header_count;
  logic                  header_bad;
  logic                  data_level;

  // frame period: wire time plus mark between breaks, against the minimum period
  logic [FRAME_W-1:0]    frame_bits;
  logic [WIRE_W-1:0]     wire_ticks;
  logic [WIRE_W-1:0]     period_sel;
  logic                  period_hit;

  assign frame_bits = FRAME_W'((FRAME_W'(transmit_slot_count) + FRAME_W'(1))
                               * FRAME_W'(dmx_pkg::BITS_PER_SLOT));

  always_ff @(posedge clk) begin
    wire_ticks <= WIRE_W'(cfg.break_ticks) + WIRE_W'(cfg.mab_ticks)
                + WIRE_W'(cfg.mbb_ticks) + WIRE_W'(frame_bits * WIRE_W'(cfg.bit_ticks));
  end

  assign period_sel = (wire_ticks > WIRE_W'(cfg.min_period_ticks))
                    ? wire_ticks : WIRE_W'(cfg.min_period_ticks);
  // saturated period: the counter stops at its top value
  assign period_hit = (WIRE_W'(frame_ticks) >= period_sel)
                   || (frame_ticks == dmx_pkg::TICK_MAX);

  assign advance = q_valid && (!m_tvalid || m_tready);
  assign q_pop   = advance;

  assign header_count = {q_item.data, count_low_byte};
  assign header_bad   = (header_count == 16'd0)
                     || (header_count < 16'(cfg.min_slots))
                     || (header_count > 16'(MAX_SLOTS));
  assign received_inc = received_slots + SLOT_W'(1);
  assign byte_inc     = byte_position + BYTE_W'(1);
  assign count_inc    = 17'(tick_count) + 17'd1;

  always_comb begin
    if (bit_position == 4'd0) begin
      data_level = 1'b0;
    end else if (bit_position <= dmx_pkg::LAST_DATA_BIT) begin
      data_level = rd_byte[3'(bit_position - 4'd1)];
    end else begin
      data_level = 1'b1;
    end
  end

  always_comb begin
    parse_phase_next         = parse_phase;
    count_low_byte_next      = count_low_byte;
    expected_slots_next      = expected_slots;
    received_slots_next      = received_slots;
    fill_bank_next           = fill_bank;
    ready_bank_next          = ready_bank;
    transmit_bank_next       = transmit_bank;
    ready_slot_count_next    = ready_slot_count;
    transmit_slot_count_next = transmit_slot_count;
    new_frame_pending_next   = new_frame_pending;
    line_phase_next          = line_phase;
    phase_ticks_next         = phase_ticks;
    frame_ticks_next         = frame_ticks;
    byte_position_next       = byte_position;
    bit_position_next        = bit_position;
    line_register_next       = line_register;
    begin_flag               = 1'b0;
    commit_flag              = 1'b0;
    error_flag               = 1'b0;
    tick_phase               = line_phase;
    tick_count               = phase_ticks;
    frame_base               = frame_ticks;
    wr_en                    = 1'b0;
    wr_bank                  = fill_bank;
    wr_pos                   = POS_W'(received_slots);
    wr_data                  = q_item.data;
    rd_en                    = 1'b0;
    rd_clr                   = 1'b0;
    rd_bank                  = transmit_bank;
    rd_pos                   = POS_W'(byte_position);

    if (q_item.kind == dmx_pkg::ITEM_BYTE) begin
      unique case (parse_phase)
        dmx_pkg::PARSE_LOW: begin
          count_low_byte_next = q_item.data;
          parse_phase_next    = dmx_pkg::PARSE_HIGH;
        end
        dmx_pkg::PARSE_HIGH: begin
          if (header_bad) begin
            error_flag       = 1'b1;
            parse_phase_next = dmx_pkg::PARSE_LOW;
          end else begin
            expected_slots_next = header_count[SLOT_W-1:0];
            received_slots_next = '0;
            parse_phase_next    = dmx_pkg::PARSE_DATA;
          end
        end
        dmx_pkg::PARSE_DATA: begin
          wr_en               = advance;
          received_slots_next = received_inc;
          if (received_inc >= expected_slots) begin
            // commit: the filled bank becomes the ready bank
            fill_bank_next         = ready_bank;
            ready_bank_next        = fill_bank;
            ready_slot_count_next  = expected_slots;
            new_frame_pending_next = 1'b1;
            commit_flag            = 1'b1;
            parse_phase_next       = dmx_pkg::PARSE_LOW;
          end
        end
        default: begin
          parse_phase_next = dmx_pkg::PARSE_LOW;
        end
      endcase
    end else begin
      if ((line_phase == dmx_pkg::PH_WAIT) && (new_frame_pending || period_hit)) begin
        tick_phase = dmx_pkg::PH_BREAK;
        tick_count = '0;
      end
      if ((tick_phase == dmx_pkg::PH_BREAK) && (tick_count == 16'd0)) begin
        begin_flag = 1'b1;
        frame_base = '0;
        if (new_frame_pending) begin
          transmit_bank_next       = ready_bank;
          ready_bank_next          = transmit_bank;
          transmit_slot_count_next = ready_slot_count;
          new_frame_pending_next   = 1'b0;
        end
      end
      frame_ticks_next = (frame_base != dmx_pkg::TICK_MAX)
                       ? frame_base + TICK_W'(1) : frame_base;
      line_phase_next  = tick_phase;
      phase_ticks_next = tick_count;

      unique case (tick_phase)
        dmx_pkg::PH_BREAK: begin
          line_register_next = 1'b0;
          if (count_inc >= 17'(cfg.break_ticks)) begin
            line_phase_next  = dmx_pkg::PH_MAB;
            phase_ticks_next = '0;
          end else begin
            phase_ticks_next = count_inc[15:0];
          end
        end
        dmx_pkg::PH_MAB: begin
          line_register_next = 1'b1;
          if (count_inc >= 17'(cfg.mab_ticks)) begin
            line_phase_next    = dmx_pkg::PH_DATA;
            phase_ticks_next   = '0;
            byte_position_next = '0;
            bit_position_next  = '0;
            rd_clr             = advance;
          end else begin
            phase_ticks_next = count_inc[15:0];
          end
        end
        dmx_pkg::PH_DATA: begin
          line_register_next = data_level;
          if (count_inc >= 17'(cfg.bit_ticks)) begin
            phase_ticks_next = '0;
            if (bit_position == dmx_pkg::LAST_BIT) begin
              bit_position_next  = '0;
              byte_position_next = byte_inc;
              if (byte_inc > BYTE_W'(transmit_slot_count)) begin
                line_phase_next = dmx_pkg::PH_WAIT;
              end else begin
                // slot byte_inc is stored at position byte_position
                rd_en = advance;
              end
            end else begin
              bit_position_next = bit_position + 4'd1;
            end
          end else begin
            phase_ticks_next = count_inc[15:0];
          end
        end
        dmx_pkg::PH_WAIT: begin
          line_register_next = 1'b1;
        end
        default: begin
          line_register_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= dmx_pkg::PARSE_LOW;
      count_low_byte      <= '0;
      expected_slots      <= '0;
      received_slots      <= '0;
      fill_bank           <= dmx_pkg::BANK_ONE;
      ready_bank          <= dmx_pkg::BANK_ZERO;
      transmit_bank       <= dmx_pkg::BANK_TWO;
      ready_slot_count    <= SLOT_W'(dmx_pkg::RST_SLOT_COUNT);
      transmit_slot_count <= SLOT_W'(dmx_pkg::RST_SLOT_COUNT);
      new_frame_pending   <= 1'b0;
      line_phase          <= dmx_pkg::PH_BREAK;
      phase_ticks         <= '0;
      frame_ticks         <= '0;
      byte_position       <= '0;
      bit_position        <= '0;
      line_register       <= 1'b0;
    end else if (advance) begin
      parse_phase         <= parse_phase_next;
      count_low_byte      <= count_low_byte_next;
      expected_slots      <= expected_slots_next;
      received_slots      <= received_slots_next;
      fill_bank           <= fill_bank_next;
      ready_bank          <= ready_bank_next;
      transmit_bank       <= transmit_bank_next;
      ready_slot_count    <= ready_slot_count_next;
      transmit_slot_count <= transmit_slot_count_next;
      new_frame_pending   <= new_frame_pending_next;
      line_phase          <= line_phase_next;
      phase_ticks         <= phase_ticks_next;
      frame_ticks         <= frame_ticks_next;
      byte_position       <= byte_position_next;
      bit_position        <= bit_position_next;
      line_register       <= line_register_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, error_flag, commit_flag, begin_flag, line_register_next};
    end
  end

  assign status.fill_bank     = fill_bank;
  assign status.ready_bank    = ready_bank;
  assign status.transmit_bank = transmit_bank;
  assign status.line_phase    = line_phase;

endmodule

// ===== sv/dmx512_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter
// an accepted item passes through the front queue and then the result register
// throughput: one item per cycle while no result waits untaken on the result stream
// reset: control state cleared, 24 zero slots queued, first tick starts a break
// the slot store is not swept; per-bank fill counts make unwritten slots read zero
// ----------------------------------------------------------------------------
module dmx512_frame_transmitter #(
  parameter int MAX_SLOTS = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,    // [7:0] host_byte
  input  logic                                 s_tuser,    // [0] action
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] line_level, [1] frame_begin, [2] frame_committed, [3] protocol_error,
  // [7:4] zero
  output logic [7:0]                           m_tdata,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [dmx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dmx_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int POS_W = $clog2(MAX_SLOTS);

  dmx_pkg::cfg_t    cfg;
  dmx_pkg::item_t   q_item;
  logic             q_valid;
  logic             q_pop;
  logic             wr_en;
  dmx_pkg::bank_t   wr_bank;
  logic [POS_W-1:0] wr_pos;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic             rd_clr;
  dmx_pkg::bank_t   rd_bank;
  logic [POS_W-1:0] rd_pos;
  logic [7:0]       rd_byte;
  dmx_pkg::status_t status;

  // configuration registers, new values act on the next tick
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.break_ticks      <= dmx_pkg::RST_BREAK_TICKS;
      cfg.mab_ticks        <= dmx_pkg::RST_MAB_TICKS;
      cfg.mbb_ticks        <= dmx_pkg::RST_MBB_TICKS;
      cfg.min_period_ticks <= dmx_pkg::RST_MIN_PERIOD_TICKS;
      cfg.bit_ticks        <= dmx_pkg::RST_BIT_TICKS;
      cfg.min_slots        <= dmx_pkg::RST_MIN_SLOTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmx_pkg::CFG_BREAK_TICKS:      cfg.break_ticks      <= cfg_data[15:0];
        dmx_pkg::CFG_MAB_TICKS:        cfg.mab_ticks        <= cfg_data[15:0];
        dmx_pkg::CFG_MBB_TICKS:        cfg.mbb_ticks        <= cfg_data[15:0];
        dmx_pkg::CFG_MIN_PERIOD_TICKS: cfg.min_period_ticks <= cfg_data[19:0];
        dmx_pkg::CFG_BIT_TICKS:        cfg.bit_ticks        <= cfg_data[7:0];
        dmx_pkg::CFG_MIN_SLOTS:        cfg.min_slots        <= cfg_data[9:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front: two-entry queue, tags each item as a tick or a host byte
  dmx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: one item per cycle through parser or line sequencer into the result register,
  // but the queue stops draining while a result waits untaken in that register
  dmx_engine #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_bank  (wr_bank),
    .wr_pos   (wr_pos),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_clr   (rd_clr),
    .rd_bank  (rd_bank),
    .rd_pos   (rd_pos),
    .rd_byte  (rd_byte),
    .status   (status)
  );

  // slot store: fill bank written by host bytes, transmit bank read a byte
  // ahead of its start bit, never the same bank in one cycle
  dmx_store #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_pos  (wr_pos),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_clr  (rd_clr),
    .rd_bank (rd_bank),
    .rd_pos  (rd_pos),
    .rd_byte (rd_byte)
  );

  // the three banks always stay a permutation of 0..2
  a_banks_distinct: assert property (@(posedge clk) disable iff (rst)
    (status.fill_bank != status.ready_bank)
    && (status.fill_bank != status.transmit_bank)
    && (status.ready_bank != status.transmit_bank)
    && (status.fill_bank != 2'd3) && (status.ready_bank != 2'd3)
    && (status.transmit_bank != 2'd3))
    else $error("slot banks overlap");

  // a break start drives the line low
  a_begin_low: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
    else $error("frame begin without line low");

  // an item is either a tick or a host byte, so at most one flag is set
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[3:1]) <= 1))
    else $error("more than one result flag set");

endmodule

// ===== bench/tb_dmx512_frame_transmitter.sv =====
// ----------------------------------------------------------------------------
// tb_dmx512_frame_transmitter
// self-checking bench: a cycle-free line predictor follows every accepted
// tick or host byte, and each result item is compared field by field in
// order, over several register settings with random stalls on both streams
// ----------------------------------------------------------------------------
module tb_dmx512_frame_transmitter;
  import dmx_pkg::*;

  localparam int MAX_SLOTS      = 512;
  localparam int WATCHDOG_LIMIT = 2000;
  // leave a little margin after the last expected result is taken
  localparam int DRAIN_CYCLES   = 4;

  // result fields, line_level in the lowest bit as on m_tdata
  typedef struct packed {
    logic protocol_error;
    logic frame_committed;
    logic frame_begin;
    logic line_level;
  } line_result_t;

  typedef struct {
    cfg_t regs;
    int   budget;
    int   burst_max;
  } phase_plan_t;

  // --------------------------------------------------------------------------
  // line predictor and result store
  // --------------------------------------------------------------------------
  class frame_line_tracker;
    cfg_t         regs;
    logic [7:0]   universe [3*MAX_SLOTS];
    parse_phase_t parse_ph;
    logic [7:0]   count_lo;
    logic [9:0]   want_slots;
    logic [9:0]   got_slots;
    bank_t        fill_b;
    bank_t        ready_b;
    bank_t        tx_b;
    logic [9:0]   ready_cnt;
    logic [9:0]   tx_cnt;
    logic         frame_waiting;
    line_phase_t  line_ph;
    logic [19:0]  phase_cnt;
    logic [19:0]  frame_cnt;
    logic [9:0]   byte_pos;
    logic [3:0]   bit_pos;
    logic [7:0]   shifter;
    logic         line;
    line_result_t awaited_results [$];
    int           failures;

    function new();
      regs.break_ticks      = RST_BREAK_TICKS;
      regs.mab_ticks        = RST_MAB_TICKS;
      regs.mbb_ticks        = RST_MBB_TICKS;
      regs.min_period_ticks = RST_MIN_PERIOD_TICKS;
      regs.bit_ticks        = RST_BIT_TICKS;
      regs.min_slots        = RST_MIN_SLOTS;
      foreach (universe[i]) universe[i] = 8'h00;
      parse_ph      = PARSE_LOW;
      count_lo      = '0;
      want_slots    = '0;
      got_slots     = '0;
      fill_b        = BANK_ONE;
      ready_b       = BANK_ZERO;
      tx_b          = BANK_TWO;
      ready_cnt     = 10'(RST_SLOT_COUNT);
      tx_cnt        = 10'(RST_SLOT_COUNT);
      frame_waiting = 1'b0;
      line_ph       = PH_BREAK;
      phase_cnt     = '0;
      frame_cnt     = '0;
      byte_pos      = '0;
      bit_pos       = '0;
      shifter       = '0;
      line          = 1'b0;
      failures      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_BREAK_TICKS:      regs.break_ticks      = value[15:0];
        CFG_MAB_TICKS:        regs.mab_ticks        = value[15:0];
        CFG_MBB_TICKS:        regs.mbb_ticks        = value[15:0];
        CFG_MIN_PERIOD_TICKS: regs.min_period_ticks = value[19:0];
        CFG_BIT_TICKS:        regs.bit_ticks        = value[7:0];
        CFG_MIN_SLOTS:        regs.min_slots        = value[9:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    // wire time plus mark between breaks, floored by the minimum period
    function logic [19:0] refresh_period();
      int unsigned line_ticks;
      line_ticks = 32'(regs.break_ticks) + 32'(regs.mab_ticks) + 32'(regs.mbb_ticks)
                 + (32'(tx_cnt) + 1) * BITS_PER_SLOT * 32'(regs.bit_ticks);
      if (line_ticks < 32'(regs.min_period_ticks)) line_ticks = 32'(regs.min_period_ticks);
      return (line_ticks > 32'(TICK_MAX)) ? TICK_MAX : line_ticks[19:0];
    endfunction

    // one microsecond of line time, returns whether a break started
    function logic advance_line();
      logic began;
      began = 1'b0;
      if (line_ph == PH_WAIT && (frame_waiting || frame_cnt >= refresh_period())) begin
        line_ph   = PH_BREAK;
        phase_cnt = '0;
      end
      if (line_ph == PH_BREAK && phase_cnt == 0) begin
        began     = 1'b1;
        frame_cnt = '0;
        // a committed frame replaces the one on the wire
        if (frame_waiting) begin
          {tx_b, ready_b} = {ready_b, tx_b};
          tx_cnt          = ready_cnt;
          frame_waiting   = 1'b0;
        end
      end
      if (frame_cnt < TICK_MAX) frame_cnt++;

      case (line_ph)
        PH_BREAK: begin
          line = 1'b0;
          phase_cnt++;
          if (phase_cnt >= 20'(regs.break_ticks)) begin
            line_ph   = PH_MAB;
            phase_cnt = '0;
          end
        end
        PH_MAB: begin
          line = 1'b1;
          phase_cnt++;
          if (phase_cnt >= 20'(regs.mab_ticks)) begin
            line_ph   = PH_DATA;
            phase_cnt = '0;
            byte_pos  = '0;
            bit_pos   = '0;
            shifter   = '0;
          end
        end
        PH_DATA: begin
          // start bit low, data lsb first, stop bits high
          if (bit_pos == 0) line = 1'b0;
          else if (bit_pos <= LAST_DATA_BIT) line = shifter[bit_pos - 1];
          else line = 1'b1;
          phase_cnt++;
          if (phase_cnt >= 20'(regs.bit_ticks)) begin
            phase_cnt = '0;
            bit_pos++;
            if (bit_pos > LAST_BIT) begin
              bit_pos = '0;
              byte_pos++;
              if (byte_pos > tx_cnt) line_ph = PH_WAIT;
              else shifter = universe[int'(tx_b) * MAX_SLOTS + int'(byte_pos) - 1];
            end
          end
        end
        default: line = 1'b1;
      endcase
      return began;
    endfunction

    function void take_host_byte(logic [7:0] b, output logic done, output logic bad);
      logic [15:0] count;
      done = 1'b0;
      bad  = 1'b0;
      case (parse_ph)
        PARSE_LOW: begin
          count_lo = b;
          parse_ph = PARSE_HIGH;
        end
        PARSE_HIGH: begin
          count = {b, count_lo};
          if (count == 0 || count < 16'(regs.min_slots) || count > 16'(MAX_SLOTS)) begin
            bad      = 1'b1;
            parse_ph = PARSE_LOW;
          end else begin
            want_slots = count[9:0];
            got_slots  = '0;
            parse_ph   = PARSE_DATA;
          end
        end
        default: begin
          universe[int'(fill_b) * MAX_SLOTS + int'(got_slots)] = b;
          got_slots++;
          if (got_slots >= want_slots) begin
            {fill_b, ready_b} = {ready_b, fill_b};
            ready_cnt         = want_slots;
            frame_waiting     = 1'b1;
            done              = 1'b1;
            parse_ph          = PARSE_LOW;
          end
        end
      endcase
    endfunction

    function void note_item(item_kind_t kind, logic [7:0] data);
      line_result_t r;
      r = '0;
      // a host byte leaves the line where it is
      if (kind == ITEM_BYTE) take_host_byte(data, r.frame_committed, r.protocol_error);
      else r.frame_begin = advance_line();
      r.line_level = line;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [7:0] seen);
      line_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result %02h arrived with nothing expected", $time, seen);
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("line_level",      4'(want.line_level),      4'(seen[0]));
      compare_field("frame_begin",     4'(want.frame_begin),     4'(seen[1]));
      compare_field("frame_committed", 4'(want.frame_committed), 4'(seen[2]));
      compare_field("protocol_error",  4'(want.protocol_error),  4'(seen[3]));
      compare_field("tdata pad",       4'h0,                     seen[7:4]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;   // [7:0] host_byte
  logic                  s_tuser = 1'b0;    // [0] action
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [0] line_level, [1] frame_begin, [2] frame_committed, [3] protocol_error
  logic [7:0]            m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dmx512_frame_transmitter #(
    .MAX_SLOTS(MAX_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  frame_line_tracker sb;
  item_t             stim_q [$];
  int                idle_cycles = 0;

  // both handshakes are seen with the values that stood before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(item_kind_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // nothing accepted on either stream for too long means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dmx512_frame_transmitter verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stretches of random stalls alternate with stretches of none
  initial begin : result_sink
    int gap;
    int left;
    bit stalling;
    left     = 0;
    stalling = 1'b0;
    @(negedge rst);
    forever begin
      if (left == 0) begin
        stalling = $urandom_range(0, 2) != 0;
        left     = $urandom_range(20, 60);
      end
      left--;
      gap = stalling ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic phase_plan_t make_plan(int brk, int mab, int mbb, int period, int bits,
                                            int slots, int budget, int burst_max);
    phase_plan_t p;
    p.regs.break_ticks      = 16'(brk);
    p.regs.mab_ticks        = 16'(mab);
    p.regs.mbb_ticks        = 16'(mbb);
    p.regs.min_period_ticks = 20'(period);
    p.regs.bit_ticks        = 8'(bits);
    p.regs.min_slots        = 10'(slots);
    p.budget                = budget;
    p.burst_max             = burst_max;
    return p;
  endfunction

  function automatic void queue_item(item_kind_t kind, logic [7:0] data);
    item_t it;
    it.kind = kind;
    it.data = data;
    stim_q.push_back(it);
  endfunction

  // host_byte is ignored on a tick, so it carries junk
  function automatic void queue_ticks(int n);
    repeat (n) queue_item(ITEM_TICK, 8'($urandom));
  endfunction

  // mostly well-formed host frames with ticks woven in, some bad headers and noise
  task automatic build_traffic(input int budget, input int burst_max, input int slot_floor);
    int          pick;
    int          lo;
    int          hi;
    logic [15:0] cnt;
    lo = (slot_floor < 1) ? 1 : slot_floor;
    hi = (lo + 5 > MAX_SLOTS) ? MAX_SLOTS : lo + 5;
    while (stim_q.size() < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_ticks($urandom_range(1, burst_max));
      end else if (pick < 80 && lo <= MAX_SLOTS) begin
        cnt = 16'($urandom_range(lo, hi));
        queue_item(ITEM_BYTE, cnt[7:0]);
        if ($urandom_range(0, 7) == 0) queue_ticks($urandom_range(1, 4));
        queue_item(ITEM_BYTE, cnt[15:8]);
        for (int i = 0; i < int'(cnt); i++) begin
          if ($urandom_range(0, 5) == 0) queue_ticks($urandom_range(1, burst_max / 4 + 1));
          queue_item(ITEM_BYTE, 8'($urandom));
        end
      end else if (pick < 92) begin
        case ($urandom_range(0, 3))
          0:       cnt = 16'h0000;
          1:       cnt = (slot_floor > 1) ? 16'(slot_floor - 1) : 16'h0000;
          2:       cnt = 16'($urandom_range(MAX_SLOTS + 1, 65535));
          default: cnt = 16'hFFFF;
        endcase
        queue_item(ITEM_BYTE, cnt[7:0]);
        queue_item(ITEM_BYTE, cnt[15:8]);
      end else begin
        queue_item(ITEM_BYTE, 8'($urandom));
      end
    end
  endtask

  // sends the queue; once per call the sender holds off until the output is empty
  task automatic drive_items();
    item_t it;
    int    gap;
    int    left;
    int    pause_at;
    int    k;
    bit    gappy;
    left     = 0;
    gappy    = 1'b0;
    k        = 0;
    pause_at = $urandom_range(0, stim_q.size() - 1);
    while (stim_q.size() != 0) begin
      if (left == 0) begin
        gappy = $urandom_range(0, 2) != 0;
        left  = $urandom_range(20, 60);
      end
      left--;
      gap = gappy ? $urandom_range(0, 12) : 0;
      if (gap != 0 || k == pause_at) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (k == pause_at) begin
          do @(posedge clk); while (sb.outstanding() != 0);
        end
      end
      it = stim_q.pop_front();
      s_tvalid <= 1'b1;
      s_tuser  <= it.kind;
      s_tdata  <= it.data;
      do @(posedge clk); while (!s_tready);
      k++;
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic settle_outputs();
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // all six registers back to back, block idle
  task automatic load_settings(input cfg_t regs);
    put_register(CFG_BREAK_TICKS,      CFG_DATA_W'(regs.break_ticks));
    put_register(CFG_MAB_TICKS,        CFG_DATA_W'(regs.mab_ticks));
    put_register(CFG_MBB_TICKS,        CFG_DATA_W'(regs.mbb_ticks));
    put_register(CFG_MIN_PERIOD_TICKS, CFG_DATA_W'(regs.min_period_ticks));
    put_register(CFG_BIT_TICKS,        CFG_DATA_W'(regs.bit_ticks));
    put_register(CFG_MIN_SLOTS,        CFG_DATA_W'(regs.min_slots));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------
  initial begin : main_flow
    phase_plan_t plans [7];
    // fast line, every count from one slot to a full universe accepted, no period floor
    plans[0] = make_plan(2, 1, 0, 0, 1, 1, 165, 20);
    // zero durations behave as one tick
    plans[1] = make_plan(0, 0, 3, 30, 0, 2, 100, 20);
    // all timing registers at their top, period saturates
    plans[2] = make_plan(65535, 65535, 65535, 1048575, 255, 1, 60, 40);
    plans[3] = make_plan(1, 2, 5, 200, 2, 3, 120, 24);
    // only full universes accepted
    plans[4] = make_plan(3, 1, 1, 1, 1, 512, 560, 30);
    // slot floor above the largest universe: every header fails
    plans[5] = make_plan(1, 1, 0, 0, 1, 1023, 60, 16);
    // slot floor of zero still rejects an empty frame
    plans[6] = make_plan(1, 1, 2, 40, 1, 0, 80, 16);

    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first tick opens a break with the 24 zero slots
    queue_ticks(1);
    queue_item(ITEM_BYTE, 8'h00);  // count of zero
    queue_item(ITEM_BYTE, 8'h00);
    queue_ticks(1);
    queue_item(ITEM_BYTE, 8'h17);  // one below the slot floor, tick between halves
    queue_ticks(1);
    queue_item(ITEM_BYTE, 8'h00);
    queue_item(ITEM_BYTE, 8'h01);  // one above the largest universe
    queue_item(ITEM_BYTE, 8'h02);
    queue_item(ITEM_BYTE, 8'hFF);  // largest count the header can hold
    queue_item(ITEM_BYTE, 8'hFF);
    queue_ticks(2);
    build_traffic(75, 40, int'(RST_MIN_SLOTS));
    drive_items();
    settle_outputs();

    foreach (plans[p]) begin
      load_settings(plans[p].regs);
      if (p == 0) begin
        // two one-slot commits before the next break: only the second goes out
        queue_item(ITEM_BYTE, 8'h01);
        queue_item(ITEM_BYTE, 8'h00);
        queue_item(ITEM_BYTE, 8'hFF);
        queue_item(ITEM_BYTE, 8'h01);
        queue_item(ITEM_BYTE, 8'h00);
        queue_item(ITEM_BYTE, 8'hA5);
        queue_ticks(12);
      end
      build_traffic(plans[p].budget, plans[p].burst_max, int'(plans[p].regs.min_slots));
      drive_items();
      settle_outputs();
    end

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("dmx512_frame_transmitter verification clean");
    end else begin
      $display("dmx512_frame_transmitter verification failed");
    end
    $finish;
  end

endmodule
